// ===== src/dcods_pkg.sv =====
// Shared types, constants and helpers for the DCO divider / RFREQ solver.
package dcods_pkg;

  // Divider candidates: six valid high-speed divider codes
  localparam int NCODE  = 6;
  localparam int PW     = 54;  // scaled output frequency p = hz * mult
  localparam int DW     = 59;  // d = 2 * p * hs
  localparam int YW     = 66;  // N divider numerator and shifted divisor
  localparam int YSTEPS = 7;   // quotient bits for the N divider (cap at 64)
  localparam int GW     = 49;  // DCO frequency inside the range
  localparam int GXW    = 65;  // full p * N * hs product
  localparam int MXW    = 53;  // 1e6 * crystal
  localparam int RW     = 92;  // RFREQ divider working width
  localparam int RSTEPS = 38;  // RFREQ quotient bits
  localparam int RFW    = 38;  // RFREQ width, Q10.28

  localparam logic [3:0] HS_VAL  [NCODE] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11};
  localparam logic [2:0] HS_CODE [NCODE] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd7};

  localparam logic [35:0] MHZ_SCALED  = 36'd65536000000;
  localparam logic [19:0] ONE_MILLION = 20'd1000000;

  // Register reset values
  localparam logic [22:0] MULT_RST     = 23'd262144;
  localparam logic [32:0] XTAL_RST     = 33'd1917384131;
  localparam logic [12:0] DCO_LOW_RST  = 13'd4850;
  localparam logic [12:0] DCO_HIGH_RST = 13'd5670;

  typedef enum logic [1:0] {
    CFG_MULT     = 2'd0,
    CFG_XTAL     = 2'd1,
    CFG_DCO_LOW  = 2'd2,
    CFG_DCO_HIGH = 2'd3
  } cfg_idx_t;

  // One divider candidate
  typedef struct packed {
    logic          found;
    logic [2:0]    code;
    logic [6:0]    n1;
    logic [GW-1:0] g;
  } cand_t;

  // Side info riding along the RFREQ divider
  typedef struct packed {
    logic       found;
    logic       sat;
    logic [2:0] code;
    logic [6:0] n1;
  } rinfo_t;

  // Keep a unless b is valid and strictly lower (lower code wins ties)
  function automatic cand_t pick_cand(cand_t a, cand_t b);
    cand_t res;
    res = a;
    if (b.found && (!a.found || (b.g < a.g))) res = b;
    return res;
  endfunction

endpackage

// ===== src/dco_divider_rfreq_solver_core.sv =====
// Top level: pipelined divider search and RFREQ computation.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  in      | in_tune_freq_hz                         | start & !busy (busy stays low)
//  out     | out_reg7..12_byte, out_hs_div_code,     | out_strobe, one cycle, no stall
//          | out_n1_value, out_rfreq_q28,            |
//          | out_solution_found                      |
//  cfg     | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// One transaction enters per clock. The pipeline holds the 38-step RFREQ
// restoring divider, after the 7-step N divider that runs for all six codes
// in parallel.
// Reset (synchronous, rst_n low) clears the valid bits and loads register defaults.
// The receiver cannot stall, so the pipeline never holds and busy is always low.
module dco_divider_rfreq_solver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] in_tune_freq_hz,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data,
  output logic        out_strobe,
  output logic [7:0]  out_reg7_byte,
  output logic [7:0]  out_reg8_byte,
  output logic [7:0]  out_reg9_byte,
  output logic [7:0]  out_reg10_byte,
  output logic [7:0]  out_reg11_byte,
  output logic [7:0]  out_reg12_byte,
  output logic [2:0]  out_hs_div_code,
  output logic [6:0]  out_n1_value,
  output logic [37:0] out_rfreq_q28,
  output logic        out_solution_found
);

  localparam int NC = dcods_pkg::NCODE;
  localparam int YS = dcods_pkg::YSTEPS;
  localparam int RS = dcods_pkg::RSTEPS;

  // Configuration registers and derived limits
  logic [22:0] mult_r;
  logic [32:0] xtal_r;
  logic [12:0] dco_low_r, dco_high_r;
  logic [dcods_pkg::GW-1:0]  lo_lim_r, hi_lim_r;
  logic [49:0]               mid_r;
  logic [dcods_pkg::MXW-1:0] mx_r;

  // Stage A/B
  logic                     va_r, vb_r;
  logic [dcods_pkg::PW-1:0] pa_r, pb_r;
  logic [dcods_pkg::DW-1:0] db_r [NC];

  // N divider stages
  logic                     yv_r    [0:YS];
  logic [dcods_pkg::PW-1:0] yp_r    [0:YS];
  logic                     yzero_r [0:YS];
  logic [dcods_pkg::YW-1:0] yrem_r  [0:YS][NC];
  logic [dcods_pkg::DW-1:0] yd_r    [0:YS][NC];
  logic [YS-1:0]            yq_r    [0:YS][NC];
  logic                     yone_r  [0:YS][NC];
  logic [dcods_pkg::YW-1:0] yrem_nxt [1:YS][NC];
  logic [YS-1:0]            yq_nxt   [1:YS][NC];

  // Product, range check and selection
  logic                      gv_r, vv_r, pv_r, fv_r;
  logic [dcods_pkg::GXW-1:0] gg_r  [NC];
  logic [6:0]                gn1_r [NC];
  logic [dcods_pkg::GXW-1:0] gg_nxt  [NC];
  logic [6:0]                gn1_nxt [NC];
  dcods_pkg::cand_t          vc_r [NC];
  dcods_pkg::cand_t          pc_r [3];
  dcods_pkg::cand_t          fc_r;

  // RFREQ divider stages
  logic                      rv_r   [0:RS];
  logic [dcods_pkg::RW-1:0]  rrem_r [0:RS];
  logic [dcods_pkg::RFW-1:0] rq_r   [0:RS];
  dcods_pkg::rinfo_t         ri_r   [0:RS];
  logic [dcods_pkg::RW-1:0]  rrem_nxt [1:RS];
  logic [dcods_pkg::RFW-1:0] rq_nxt   [1:RS];
  logic [dcods_pkg::RW-1:0]  rnum_nxt, rdiv2;

  // Output registers
  logic        out_strobe_r, out_found_r;
  logic [2:0]  out_code_r;
  logic [6:0]  out_n1_r;
  logic [37:0] out_rf_r;
  logic [37:0] rf_nxt;

  logic [22:0] mult_eff;
  logic [32:0] xtal_eff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign mult_eff  = (mult_r == '0) ? 23'd1 : mult_r;
  assign xtal_eff  = (xtal_r == '0) ? 33'd1 : xtal_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r     <= dcods_pkg::MULT_RST;
      xtal_r     <= dcods_pkg::XTAL_RST;
      dco_low_r  <= dcods_pkg::DCO_LOW_RST;
      dco_high_r <= dcods_pkg::DCO_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dcods_pkg::cfg_idx_t'(cfg_index))
        dcods_pkg::CFG_MULT:     mult_r     <= cfg_data[22:0];
        dcods_pkg::CFG_XTAL:     xtal_r     <= cfg_data;
        dcods_pkg::CFG_DCO_LOW:  dco_low_r  <= cfg_data[12:0];
        dcods_pkg::CFG_DCO_HIGH: dco_high_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Derived limits, used from stage B on
  always_ff @(posedge clk) begin
    lo_lim_r <= dcods_pkg::GW'(49'(dco_low_r) * 49'(dcods_pkg::MHZ_SCALED));
    hi_lim_r <= dcods_pkg::GW'(49'(dco_high_r) * 49'(dcods_pkg::MHZ_SCALED));
    mid_r    <= 50'(50'(50'(dco_low_r) + 50'(dco_high_r))
                    * 50'(dcods_pkg::ONE_MILLION)) << 16;
    mx_r     <= dcods_pkg::MXW'(53'(xtal_eff) * 53'(dcods_pkg::ONE_MILLION));
  end

  // N divider steps: quotient of (mid + d) / 2d, bit 6 meaning cap at 64
  always_comb begin
    for (int s = 0; s < YS; s++) begin
      for (int c = 0; c < NC; c++) begin
        yrem_nxt[s+1][c] = yrem_r[s][c];
        yq_nxt[s+1][c]   = yq_r[s][c];
        if (yrem_r[s][c] >= (dcods_pkg::YW'(yd_r[s][c]) << (YS - s))) begin
          yrem_nxt[s+1][c] = yrem_r[s][c] - (dcods_pkg::YW'(yd_r[s][c]) << (YS - s));
          yq_nxt[s+1][c][YS-1-s] = 1'b1;
        end
      end
    end
  end

  // Divider N, product and DCO frequency per code
  always_comb begin
    logic [7:0]  y;
    logic [10:0] m;
    for (int c = 0; c < NC; c++) begin
      if (yzero_r[YS])
        y = 8'd128;
      else if (yone_r[YS][c])
        y = 8'd1;
      else if (yq_r[YS][c][YS-1])
        y = 8'd128;
      else
        y = {1'b0, yq_r[YS][c][YS-2:0], 1'b0};
      m          = 11'(y) * 11'(dcods_pkg::HS_VAL[c]);
      gg_nxt[c]  = dcods_pkg::GXW'(yp_r[YS]) * dcods_pkg::GXW'(m);
      gn1_nxt[c] = 7'(y - 8'd1);
    end
  end

  // RFREQ divider: numerator g*2^37 + m, divisor 2m, one bit per stage
  assign rdiv2    = dcods_pkg::RW'(mx_r) << 1;
  assign rnum_nxt = (dcods_pkg::RW'(fc_r.g) << 37) + dcods_pkg::RW'(mx_r);

  always_comb begin
    for (int i = 0; i < RS; i++) begin
      rrem_nxt[i+1] = rrem_r[i];
      rq_nxt[i+1]   = rq_r[i];
      if (rrem_r[i] >= (rdiv2 << (RS - 1 - i))) begin
        rrem_nxt[i+1] = rrem_r[i] - (rdiv2 << (RS - 1 - i));
        rq_nxt[i+1][RS-1-i] = 1'b1;
      end
    end
  end

  assign rf_nxt = ri_r[RS].sat ? '1 : rq_r[RS];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      for (int s = 0; s <= YS; s++) yv_r[s] <= 1'b0;
      gv_r <= 1'b0;
      vv_r <= 1'b0;
      pv_r <= 1'b0;
      fv_r <= 1'b0;
      for (int i = 0; i <= RS; i++) rv_r[i] <= 1'b0;
      out_strobe_r <= 1'b0;
      out_found_r  <= 1'b0;
    end else begin
      va_r    <= start && !busy;
      vb_r    <= va_r;
      yv_r[0] <= vb_r;
      for (int s = 0; s < YS; s++) yv_r[s+1] <= yv_r[s];
      gv_r    <= yv_r[YS];
      vv_r    <= gv_r;
      pv_r    <= vv_r;
      fv_r    <= pv_r;
      rv_r[0] <= fv_r;
      for (int i = 0; i < RS; i++) rv_r[i+1] <= rv_r[i];
      out_strobe_r <= rv_r[RS];
      out_found_r  <= rv_r[RS] && ri_r[RS].found;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // A: scaled frequency
    pa_r <= dcods_pkg::PW'(54'(in_tune_freq_hz) * 54'(mult_eff));
    // B: d = 2 * p * hs
    pb_r <= pa_r;
    for (int c = 0; c < NC; c++)
      db_r[c] <= dcods_pkg::DW'(59'(pa_r) * 59'({dcods_pkg::HS_VAL[c], 1'b0}));
    // N divider load
    yp_r[0]    <= pb_r;
    yzero_r[0] <= (pb_r == '0);
    for (int c = 0; c < NC; c++) begin
      yrem_r[0][c] <= dcods_pkg::YW'(mid_r) + dcods_pkg::YW'(db_r[c]);
      yd_r[0][c]   <= db_r[c];
      yq_r[0][c]   <= '0;
      yone_r[0][c] <= ((62'(mid_r) << 1) < (62'(db_r[c]) * 62'(3)));
    end
    // N divider steps
    for (int s = 0; s < YS; s++) begin
      yp_r[s+1]    <= yp_r[s];
      yzero_r[s+1] <= yzero_r[s];
      for (int c = 0; c < NC; c++) begin
        yrem_r[s+1][c] <= yrem_nxt[s+1][c];
        yd_r[s+1][c]   <= yd_r[s][c];
        yq_r[s+1][c]   <= yq_nxt[s+1][c];
        yone_r[s+1][c] <= yone_r[s][c];
      end
    end
    // DCO frequency per code
    for (int c = 0; c < NC; c++) begin
      gg_r[c]  <= gg_nxt[c];
      gn1_r[c] <= gn1_nxt[c];
    end
    // Range check
    for (int c = 0; c < NC; c++) begin
      vc_r[c].found <= (gg_r[c] >= dcods_pkg::GXW'(lo_lim_r)) &&
                       (gg_r[c] <= dcods_pkg::GXW'(hi_lim_r));
      vc_r[c].code  <= dcods_pkg::HS_CODE[c];
      vc_r[c].n1    <= gn1_r[c];
      vc_r[c].g     <= gg_r[c][dcods_pkg::GW-1:0];
    end
    // Lowest DCO frequency: pairs, then the final pick
    pc_r[0] <= dcods_pkg::pick_cand(vc_r[0], vc_r[1]);
    pc_r[1] <= dcods_pkg::pick_cand(vc_r[2], vc_r[3]);
    pc_r[2] <= dcods_pkg::pick_cand(vc_r[4], vc_r[5]);
    fc_r    <= dcods_pkg::pick_cand(dcods_pkg::pick_cand(pc_r[0], pc_r[1]), pc_r[2]);
    // RFREQ divider load, with saturation check
    rrem_r[0]     <= rnum_nxt;
    rq_r[0]       <= '0;
    ri_r[0].found <= fc_r.found;
    ri_r[0].sat   <= (rnum_nxt >= (rdiv2 << RS));
    ri_r[0].code  <= fc_r.code;
    ri_r[0].n1    <= fc_r.n1;
    for (int i = 0; i < RS; i++) begin
      rrem_r[i+1] <= rrem_nxt[i+1];
      rq_r[i+1]   <= rq_nxt[i+1];
      ri_r[i+1]   <= ri_r[i];
    end
    // Result, zeroed when nothing fits
    out_code_r <= ri_r[RS].found ? ri_r[RS].code : 3'd0;
    out_n1_r   <= ri_r[RS].found ? ri_r[RS].n1 : 7'd0;
    out_rf_r   <= ri_r[RS].found ? rf_nxt : 38'd0;
  end

  // Register byte packing
  assign out_strobe         = out_strobe_r;
  assign out_solution_found = out_found_r;
  assign out_hs_div_code    = out_code_r;
  assign out_n1_value       = out_n1_r;
  assign out_rfreq_q28      = out_rf_r;
  assign out_reg7_byte      = {out_code_r, out_n1_r[6:2]};
  assign out_reg8_byte      = {out_n1_r[1:0], out_rf_r[37:32]};
  assign out_reg9_byte      = out_rf_r[31:24];
  assign out_reg10_byte     = out_rf_r[23:16];
  assign out_reg11_byte     = out_rf_r[15:8];
  assign out_reg12_byte     = out_rf_r[7:0];

  // Checks
  a_found_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_solution_found |-> out_strobe)
    else $error("solution flag without a result strobe");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_solution_found) |->
      (out_rfreq_q28 == 38'd0 && out_n1_value == 7'd0 && out_hs_div_code == 3'd0))
    else $error("result without solution is not all zero");

  a_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_solution_found |-> (out_hs_div_code != 3'd4 && out_hs_div_code != 3'd6))
    else $error("unused divider code selected");

  a_n1_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_solution_found |-> (out_n1_value == 7'd0 || out_n1_value[0]))
    else $error("output divider neither one nor even");

endmodule

// ===== bench/dcods_checker.sv =====
// Checker for the DCO divider solver: tracks registers, predicts each result and compares.
module dcods_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [30:0] in_tune_freq_hz,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data,
  input  logic        out_strobe,
  input  logic [7:0]  out_reg7_byte,
  input  logic [7:0]  out_reg8_byte,
  input  logic [7:0]  out_reg9_byte,
  input  logic [7:0]  out_reg10_byte,
  input  logic [7:0]  out_reg11_byte,
  input  logic [7:0]  out_reg12_byte,
  input  logic [2:0]  out_hs_div_code,
  input  logic [6:0]  out_n1_value,
  input  logic [37:0] out_rfreq_q28,
  input  logic        out_solution_found,
  output int          errors,
  output int          pending,
  output int          solved_cnt
);

  typedef struct {
    logic [7:0]  r7, r8, r9, r10, r11, r12;
    logic [2:0]  code;
    logic [6:0]  n1;
    logic [37:0] rfreq;
    logic        found;
  } tuning_t;

  localparam logic [63:0] HZ_PER_MHZ_Q16 = 64'd65536000000;
  localparam logic [63:0] RFREQ_TOP      = (64'd1 << 38) - 64'd1;

  // Shadow copies of the configuration registers
  logic [22:0] mult_q16;
  logic [32:0] xtal_q24;
  logic [12:0] dco_lo, dco_hi;

  tuning_t tunings_due[$];

  // Divider search plus RFREQ for one dial frequency
  function automatic tuning_t solve_tuning(logic [30:0] hz);
    int          hs_of [8] = '{4, 5, 6, 7, 0, 9, 0, 11};
    logic [63:0] mult, xtal, p, lo_lim, hi_lim, mid, d, y, m, g, best_g, rf, dxt;
    logic [127:0] num;
    logic [2:0]  best_code;
    logic [6:0]  best_n1;
    logic        found;
    tuning_t     t;
    mult   = (mult_q16 == 0) ? 64'd1 : 64'(mult_q16);
    xtal   = (xtal_q24 == 0) ? 64'd1 : 64'(xtal_q24);
    p      = 64'(hz) * mult;
    lo_lim = 64'(dco_lo) * HZ_PER_MHZ_Q16;
    hi_lim = 64'(dco_hi) * HZ_PER_MHZ_Q16;
    mid    = (64'(dco_lo) + 64'(dco_hi)) * HZ_PER_MHZ_Q16;
    found  = 1'b0;
    best_g = 0; best_code = 0; best_n1 = 0;
    for (int c = 0; c < 8; c++) begin
      if (hs_of[c] == 0) continue;
      d = 64'd2 * p * 64'(hs_of[c]);
      if (d == 0) y = 128;
      else if (2 * mid < 3 * d) y = 1;
      else begin
        y = 2 * ((mid + d) / (2 * d));
        if (y > 128) y = 128;
      end
      m = y * 64'(hs_of[c]);
      if (p > hi_lim / m) continue;
      g = p * m;
      if (g < lo_lim) continue;
      if (!found || g < best_g) begin
        found = 1'b1; best_g = g; best_code = 3'(c); best_n1 = 7'(y - 1);
      end
    end
    t = '{default: '0};
    if (!found) return t;
    // Round half up of g*2^36 / (1e6*xtal), saturating to Q10.28
    dxt = 64'd1000000 * xtal;
    num = ({64'd0, best_g} << 37) + 128'(dxt);
    num = num / (128'(dxt) << 1);
    rf  = (num > 128'(RFREQ_TOP)) ? RFREQ_TOP : num[63:0];
    t.r7    = {best_code, best_n1[6:2]};
    t.r8    = {best_n1[1:0], rf[37:32]};
    t.r9    = rf[31:24];
    t.r10   = rf[23:16];
    t.r11   = rf[15:8];
    t.r12   = rf[7:0];
    t.code  = best_code;
    t.n1    = best_n1;
    t.rfreq = rf[37:0];
    t.found = 1'b1;
    return t;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  assign pending = tunings_due.size();

  // Register writes, input transactions and result transactions
  always @(posedge clk) begin
    tuning_t t;
    if (!rst_n) begin
      mult_q16 <= dcods_pkg::MULT_RST;
      xtal_q24 <= dcods_pkg::XTAL_RST;
      dco_lo   <= dcods_pkg::DCO_LOW_RST;
      dco_hi   <= dcods_pkg::DCO_HIGH_RST;
      tunings_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (dcods_pkg::cfg_idx_t'(cfg_index))
          dcods_pkg::CFG_MULT:     mult_q16 <= cfg_data[22:0];
          dcods_pkg::CFG_XTAL:     xtal_q24 <= cfg_data;
          dcods_pkg::CFG_DCO_LOW:  dco_lo   <= cfg_data[12:0];
          dcods_pkg::CFG_DCO_HIGH: dco_hi   <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (start && !busy) tunings_due.push_back(solve_tuning(in_tune_freq_hz));
      if (out_strobe) begin
        if (tunings_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual rfreq %0h",
                   $time, out_rfreq_q28);
        end else begin
          t = tunings_due.pop_front();
          if (t.found) solved_cnt++;
          check_field("reg7", t.r7, out_reg7_byte);
          check_field("reg8", t.r8, out_reg8_byte);
          check_field("reg9", t.r9, out_reg9_byte);
          check_field("reg10", t.r10, out_reg10_byte);
          check_field("reg11", t.r11, out_reg11_byte);
          check_field("reg12", t.r12, out_reg12_byte);
          check_field("hs_div_code", t.code, out_hs_div_code);
          check_field("n1_value", t.n1, out_n1_value);
          check_field("rfreq_q28", t.rfreq, out_rfreq_q28);
          check_field("solution_found", t.found, out_solution_found);
        end
      end
    end
  end

  initial begin
    errors = 0;
    solved_cnt = 0;
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the DCO divider solver: clock, reset, stimulus and verdict.
module tb_top;

  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [30:0] in_tune_freq_hz = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [32:0] cfg_data = '0;
  logic        out_strobe;
  logic [7:0]  out_reg7_byte, out_reg8_byte, out_reg9_byte;
  logic [7:0]  out_reg10_byte, out_reg11_byte, out_reg12_byte;
  logic [2:0]  out_hs_div_code;
  logic [6:0]  out_n1_value;
  logic [37:0] out_rfreq_q28;
  logic        out_solution_found;
  int          errors, pending, solved_cnt;
  int          sent_cnt = 0;
  int          cycle_cnt = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dco_divider_rfreq_solver_core DUT (.*);

  dcods_checker checker_i (.*);

  // Run-time limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // One register write transaction
  task automatic write_reg(dcods_pkg::cfg_idx_t idx, logic [32:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all results, then let the pipeline empty
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // One tuning transaction followed by a random gap
  task automatic send_tune(logic [30:0] hz, bit no_gaps);
    int gap;
    start <= 1'b1;
    in_tune_freq_hz <= hz;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_cnt++;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Log-spread dial frequency, mostly around the solvable band
  function automatic logic [30:0] rand_hz(logic [22:0] mult);
    int unsigned w;
    logic [63:0] f;
    if ($urandom_range(0, 3) != 0) begin
      f = 64'($urandom_range(3_500_000, 1_400_000_000)) << ($urandom_range(0, 2) * 2);
      f = (f << 16) / ((mult == 0) ? 64'd1 : 64'(mult));
      return (f > 64'h7fffffff) ? 31'h7fffffff : f[30:0];
    end
    w = $urandom_range(1, 31);
    return 31'($urandom & ((64'd1 << w) - 1));
  endfunction

  task automatic run_phase(logic [22:0] m, logic [32:0] x, logic [12:0] lo,
                           logic [12:0] hi, int count);
    bit burst;
    write_reg(dcods_pkg::CFG_MULT, 33'(m));
    write_reg(dcods_pkg::CFG_XTAL, x);
    write_reg(dcods_pkg::CFG_DCO_LOW, 33'(lo));
    write_reg(dcods_pkg::CFG_DCO_HIGH, 33'(hi));
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      send_tune(rand_hz(m), burst);
      if (i == count / 2) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    logic [30:0] directed [] = '{31'd0, 31'd1, 31'h7fffffff, 31'h55555555, 31'h2aaaaaaa,
                                 31'd7050000, 31'd14074000, 31'd3500000, 31'd1000000,
                                 31'd28000000, 31'd144000000, 31'd1350000000, 31'd900000,
                                 31'd855000, 31'd10000000, 31'd50000000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed values under reset settings
    foreach (directed[i]) send_tune(directed[i], i % 3 == 0);
    drain();

    // Swept settings: fixed ones with extremes, then random ones
    run_phase(23'd262144, 33'd1917384131, 13'd4850, 13'd5670, 250);
    run_phase(23'd6553600, 33'd5033164800, 13'd1000, 13'd8000, 200);
    run_phase(23'd1, 33'd1, 13'd1000, 13'd1000, 150);
    run_phase(23'd0, 33'd0, 13'd8000, 13'd8000, 100);
    run_phase(23'h7fffff, 33'h1ffffffff, 13'h1fff, 13'h1fff, 100);
    run_phase(23'd65536, 33'd1917384131, 13'd5670, 13'd4850, 100);
    for (int k = 0; k < 5; k++)
      run_phase(23'($urandom_range(1, 6553600)),
                {1'($urandom_range(0, 1)), 32'($urandom)},
                13'($urandom_range(1000, 5000)), 13'($urandom_range(5000, 8000)), 130);

    $display("tb_top: %0d tuning transactions over 12 register settings, %0d solved",
             sent_cnt, solved_cnt);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== dco_divider_rfreq_solver_core.f =====
src/dcods_pkg.sv
src/dco_divider_rfreq_solver_core.sv
bench/dcods_checker.sv
bench/tb_top.sv
